### hdl/lcd_pixel_command_serializer_assert.svh
// Assertion macros used by the checker of the serializer
`ifndef LCD_PIXEL_COMMAND_SERIALIZER_ASSERT_SVH
`define LCD_PIXEL_COMMAND_SERIALIZER_ASSERT_SVH

// Check a same-cycle implication outside reset
`define LPCS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpcs check failed");

// Check a next-cycle implication outside reset
`define LPCS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpcs check failed");

// Check a next-cycle implication at every edge, reset included
`define LPCS_ASSERT_NEXT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("lpcs check failed");

`endif

### hdl/lpcs_pkg.sv
package lpcs_pkg;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_WINDOW = 2'd1,
    KIND_COLOR  = 2'd2,
    KIND_ORIENT = 2'd3
  } kind_t;

  localparam logic [1:0] ACT_PIXEL  = 2'd0;
  localparam logic [1:0] ACT_WINDOW = 2'd1;
  localparam logic [1:0] ACT_COLOR  = 2'd2;
  localparam logic [1:0] ACT_ORIENT = 2'd3;

  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_PANEL_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PANEL_HEIGHT = 2'd1;
  localparam logic [9:0] PANEL_WIDTH_RESET  = 10'd320;
  localparam logic [9:0] PANEL_HEIGHT_RESET = 10'd480;

  localparam logic [7:0] CMD_COLUMN_SET   = 8'h2A;
  localparam logic [7:0] CMD_PAGE_SET     = 8'h2B;
  localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;
  localparam logic [7:0] CMD_ACCESS_CTRL  = 8'h36;

  typedef logic [3:0] step_t;

  localparam step_t STEP_COL_CMD     = 4'd0;
  localparam step_t STEP_X1_HI       = 4'd1;
  localparam step_t STEP_X1_LO       = 4'd2;
  localparam step_t STEP_X2_HI       = 4'd3;
  localparam step_t STEP_X2_LO       = 4'd4;
  localparam step_t STEP_PAGE_CMD    = 4'd5;
  localparam step_t STEP_Y1_HI       = 4'd6;
  localparam step_t STEP_Y1_LO       = 4'd7;
  localparam step_t STEP_Y2_HI       = 4'd8;
  localparam step_t STEP_Y2_LO       = 4'd9;
  localparam step_t STEP_MEMWR_CMD   = 4'd10;
  localparam step_t STEP_RED         = 4'd11;
  localparam step_t STEP_GREEN       = 4'd12;
  localparam step_t STEP_BLUE        = 4'd13;
  localparam step_t STEP_ORIENT_CMD  = 4'd14;
  localparam step_t STEP_ORIENT_MODE = 4'd15;

  typedef struct packed {
    kind_t      kind;
    logic [10:0] x1;
    logic [10:0] x2;
    logic [10:0] y1;
    logic [10:0] y2;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  mode;
  } desc_t;

  // v*255/31 as v*255*8457 >> 18
  function automatic logic [7:0] scale5(input logic [4:0] v);
    logic [26:0] p;
    p = 27'(v) * 27'd2156535;
    return p[25:18];
  endfunction

  // v*255/63 as v*255*16645 >> 20
  function automatic logic [7:0] scale6(input logic [5:0] v);
    logic [28:0] p;
    p = 29'(v) * 29'd4244475;
    return p[27:20];
  endfunction

  function automatic logic [7:0] mode_byte(input logic [1:0] m);
    logic [7:0] b;
    case (m)
      2'd0:    b = 8'h08;
      2'd1:    b = 8'h68;
      2'd2:    b = 8'hC8;
      default: b = 8'hA8;
    endcase
    return b;
  endfunction

endpackage

### hdl/lpcs_front.sv
module lpcs_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lpcs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [9:0]                       cfg_data,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [1:0]                       in_tuser,
  input  logic [63:0]                      in_tdata,
  input  logic                             q_full,
  output logic                             push,
  output lpcs_pkg::desc_t                  push_desc
);
  import lpcs_pkg::*;

  logic [9:0] panel_width_r;
  logic [9:0] panel_height_r;
  logic [9:0] start_x;
  logic [9:0] start_y;
  logic [9:0] end_x;
  logic [9:0] end_y;
  logic [15:0] color;
  logic [2:0]  orientation;
  logic        keep;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      panel_width_r  <= PANEL_WIDTH_RESET;
      panel_height_r <= PANEL_HEIGHT_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_PANEL_WIDTH) begin
        panel_width_r <= cfg_data;
      end
      if (cfg_index == REG_PANEL_HEIGHT) begin
        panel_height_r <= cfg_data;
      end
    end
  end

  assign start_x     = in_tdata[9:0];
  assign start_y     = in_tdata[19:10];
  assign end_x       = in_tdata[29:20];
  assign end_y       = in_tdata[39:30];
  assign color       = in_tdata[55:40];
  assign orientation = in_tdata[58:56];

  always_comb begin
    push_desc.kind  = KIND_PIXEL;
    push_desc.x1    = {1'b0, start_x};
    push_desc.y1    = {1'b0, start_y};
    push_desc.x2    = {1'b0, start_x} + 11'd1;
    push_desc.y2    = {1'b0, start_y} + 11'd1;
    push_desc.red   = scale5(color[15:11]);
    push_desc.green = scale6(color[10:5]);
    push_desc.blue  = scale5(color[4:0]);
    push_desc.mode  = mode_byte(orientation[1:0]);
    keep            = 1'b1;
    unique case (in_tuser)
      ACT_PIXEL: begin
        push_desc.kind = KIND_PIXEL;
        keep = (start_x < panel_width_r) && (start_y < panel_height_r);
      end
      ACT_WINDOW: begin
        push_desc.kind = KIND_WINDOW;
        push_desc.x2   = {1'b0, end_x};
        push_desc.y2   = {1'b0, end_y};
      end
      ACT_COLOR: begin
        push_desc.kind = KIND_COLOR;
      end
      ACT_ORIENT: begin
        push_desc.kind = KIND_ORIENT;
        keep = !orientation[2];
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_tready = !q_full;
  assign push      = in_tvalid && in_tready && keep;

endmodule

### hdl/lpcs_queue.sv
module lpcs_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lpcs_pkg::desc_t push_desc,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output lpcs_pkg::desc_t head
);
  import lpcs_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  desc_t             slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic [PTR_W-1:0]  wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_nxt;
  logic [CNT_W-1:0]  count_nxt;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

### hdl/lpcs_back.sv
module lpcs_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  lpcs_pkg::desc_t head,
  output logic            pop,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [7:0]      out_tdata,
  output logic            out_tuser,
  output logic            out_tlast
);
  import lpcs_pkg::*;

  logic       busy_r;
  logic       busy_nxt;
  step_t      step_r;
  step_t      step_nxt;
  desc_t      cur_r;
  desc_t      cur_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic [7:0] byte_r;
  logic [7:0] byte_nxt;
  logic       data_r;
  logic       data_nxt;
  logic       last_r;
  logic       last_nxt;

  desc_t      src;
  step_t      step;
  step_t      first_step;
  logic [7:0] sel_byte;
  logic       sel_data;
  logic       sel_last;
  logic       advance;
  logic       emit;

  always_comb begin
    unique case (head.kind)
      KIND_COLOR:  first_step = STEP_RED;
      KIND_ORIENT: first_step = STEP_ORIENT_CMD;
      default:     first_step = STEP_COL_CMD;
    endcase
  end

  assign src     = busy_r ? cur_r : head;
  assign step    = busy_r ? step_r : first_step;
  assign advance = !out_valid_r || out_tready;
  assign emit    = advance && (busy_r || !q_empty);
  assign pop     = emit && !busy_r;

  always_comb begin
    sel_data = 1'b1;
    unique case (step)
      STEP_COL_CMD: begin
        sel_byte = CMD_COLUMN_SET;
        sel_data = 1'b0;
      end
      STEP_X1_HI:    sel_byte = {5'd0, src.x1[10:8]};
      STEP_X1_LO:    sel_byte = src.x1[7:0];
      STEP_X2_HI:    sel_byte = {5'd0, src.x2[10:8]};
      STEP_X2_LO:    sel_byte = src.x2[7:0];
      STEP_PAGE_CMD: begin
        sel_byte = CMD_PAGE_SET;
        sel_data = 1'b0;
      end
      STEP_Y1_HI:    sel_byte = {5'd0, src.y1[10:8]};
      STEP_Y1_LO:    sel_byte = src.y1[7:0];
      STEP_Y2_HI:    sel_byte = {5'd0, src.y2[10:8]};
      STEP_Y2_LO:    sel_byte = src.y2[7:0];
      STEP_MEMWR_CMD: begin
        sel_byte = CMD_MEMORY_WRITE;
        sel_data = 1'b0;
      end
      STEP_RED:      sel_byte = src.red;
      STEP_GREEN:    sel_byte = src.green;
      STEP_BLUE:     sel_byte = src.blue;
      STEP_ORIENT_CMD: begin
        sel_byte = CMD_ACCESS_CTRL;
        sel_data = 1'b0;
      end
      default:       sel_byte = src.mode;
    endcase
  end

  assign sel_last = ((step == STEP_MEMWR_CMD) && (src.kind == KIND_WINDOW))
                 || (step == STEP_BLUE)
                 || (step == STEP_ORIENT_MODE);

  always_comb begin
    busy_nxt      = busy_r;
    step_nxt      = step_r;
    cur_nxt       = cur_r;
    out_valid_nxt = out_valid_r;
    byte_nxt      = byte_r;
    data_nxt      = data_r;
    last_nxt      = last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      byte_nxt      = sel_byte;
      data_nxt      = sel_data;
      last_nxt      = sel_last;
      busy_nxt      = !sel_last;
      cur_nxt       = src;
      step_nxt      = step + 1'b1;
    end else if (advance) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    cur_r  <= cur_nxt;
    byte_r <= byte_nxt;
    data_r <= data_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = byte_r;
  assign out_tuser  = data_r;
  assign out_tlast  = last_r;

endmodule

### hdl/lcd_pixel_command_serializer.sv
// An accepted item goes into the request queue, then to the output register.
// One word per cycle from the byte sequencer unless out_tready stalls it;
// words per item: pixel 14, window 11, color 3, orientation 2, dropped 0.
// Input is taken every cycle while the request queue has room.
// Reset (rst_n low, synchronous): queue and sequencer empty, output invalid,
// panel width 320 and height 480.
module lcd_pixel_command_serializer #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lpcs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [9:0]                       cfg_data,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // action
  input  logic [1:0]                       in_tuser,
  // start_x, start_y, end_x, end_y, color, orientation, zero pad
  input  logic [63:0]                      in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // out_byte
  output logic [7:0]                       out_tdata,
  // is_data
  output logic                             out_tuser,
  output logic                             out_tlast
);
  import lpcs_pkg::*;

  logic  q_full;
  logic  q_empty;
  logic  push;
  logic  pop;
  desc_t push_desc;
  desc_t head;

  lpcs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .push      (push),
    .push_desc (push_desc)
  );

  lpcs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .head      (head)
  );

  lpcs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

### hdl/lpcs_checker.sv
`include "lcd_pixel_command_serializer_assert.svh"

module lpcs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tuser,
  input logic       out_tlast
);
  import lpcs_pkg::*;

  // hold a stalled word
  `LPCS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

  // drop output valid out of reset
  `LPCS_ASSERT_NEXT_ALWAYS(a_reset_idle, !rst_n, !out_tvalid)

  // never close a request on a column, page or access command
  `LPCS_ASSERT_NOW(a_cmd_not_last, out_tvalid && !out_tuser &&
    (out_tdata == CMD_COLUMN_SET || out_tdata == CMD_PAGE_SET ||
     out_tdata == CMD_ACCESS_CTRL), !out_tlast)

  // follow a column command with a data word
  `LPCS_ASSERT_NEXT(a_col_then_data, out_tvalid && out_tready && !out_tuser &&
    out_tdata == CMD_COLUMN_SET, !out_tvalid || out_tuser)

endmodule

bind lcd_pixel_command_serializer lpcs_checker u_lpcs_checker (.*);

### sim/lcd_byte_stream_checker.sv
`timescale 1ns / 1ps

module lcd_byte_stream_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [lpcs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [9:0]  cfg_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [1:0]  in_tuser,
  input  logic [63:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,
  input  logic        out_tuser,
  input  logic        out_tlast,
  output int          failures,
  output int          pending
);
  import lpcs_pkg::*;

  typedef struct packed {
    logic [7:0] value;
    logic       dc;
    logic       tail;
  } link_byte_t;

  localparam logic [31:0] MODE_CODES = {8'hA8, 8'hC8, 8'h68, 8'h08};

  link_byte_t awaited_bytes[$];
  logic [9:0] cols = PANEL_WIDTH_RESET;
  logic [9:0] rows = PANEL_HEIGHT_RESET;

  function automatic void push_byte(logic [7:0] v, logic dc);
    awaited_bytes.push_back('{value: v, dc: dc, tail: 1'b0});
  endfunction

  function automatic void push_pair(logic [10:0] v);
    push_byte({5'd0, v[10:8]}, 1'b1);
    push_byte(v[7:0], 1'b1);
  endfunction

  function automatic void push_window(logic [10:0] x1, logic [10:0] y1,
                                      logic [10:0] x2, logic [10:0] y2);
    push_byte(CMD_COLUMN_SET, 1'b0);
    push_pair(x1);
    push_pair(x2);
    push_byte(CMD_PAGE_SET, 1'b0);
    push_pair(y1);
    push_pair(y2);
    push_byte(CMD_MEMORY_WRITE, 1'b0);
  endfunction

  function automatic void push_rgb888(logic [15:0] c);
    int unsigned r, g, b;
    r = c[15:11];
    g = c[10:5];
    b = c[4:0];
    push_byte(8'((r * 255) / 31), 1'b1);
    push_byte(8'((g * 255) / 63), 1'b1);
    push_byte(8'((b * 255) / 31), 1'b1);
  endfunction

  function automatic void predict_link_bytes(logic [1:0] act, logic [63:0] word);
    logic [9:0]  sx, sy, ex, ey;
    logic [15:0] colour;
    logic [2:0]  mode;
    int          prior_count;
    sx     = word[9:0];
    sy     = word[19:10];
    ex     = word[29:20];
    ey     = word[39:30];
    colour = word[55:40];
    mode   = word[58:56];
    prior_count = awaited_bytes.size();
    case (act)
      ACT_PIXEL: begin
        if (sx < cols && sy < rows) begin
          push_window({1'b0, sx}, {1'b0, sy}, 11'(sx) + 11'd1, 11'(sy) + 11'd1);
          push_rgb888(colour);
        end
      end
      ACT_WINDOW: push_window({1'b0, sx}, {1'b0, sy}, {1'b0, ex}, {1'b0, ey});
      ACT_COLOR: push_rgb888(colour);
      default: begin
        if (mode <= 3'd3) begin
          push_byte(CMD_ACCESS_CTRL, 1'b0);
          push_byte(MODE_CODES[mode[1:0]*8 +: 8], 1'b1);
        end
      end
    endcase
    if (awaited_bytes.size() > prior_count)
      awaited_bytes[awaited_bytes.size()-1].tail = 1'b1;
  endfunction

  function automatic void note_failure(string what, link_byte_t want, link_byte_t got);
    if (failures < 10)
      $display("%0t %s: expected byte %02h dc %0b last %0b, got byte %02h dc %0b last %0b",
               $realtime, what, want.value, want.dc, want.tail,
               got.value, got.dc, got.tail);
    failures++;
  endfunction

  always @(posedge clk) begin
    link_byte_t got, want;
    if (!rst_n) begin
      cols = PANEL_WIDTH_RESET;
      rows = PANEL_HEIGHT_RESET;
      failures = 0;
      awaited_bytes.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PANEL_WIDTH:  cols = cfg_data;
          REG_PANEL_HEIGHT: rows = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        predict_link_bytes(in_tuser, in_tdata);
      if (out_tvalid && out_tready) begin
        got = '{value: out_tdata, dc: out_tuser, tail: out_tlast};
        if (awaited_bytes.size() == 0) begin
          note_failure("unexpected word", '0, got);
        end else begin
          want = awaited_bytes.pop_front();
          if (got.value !== want.value || got.dc !== want.dc || got.tail !== want.tail)
            note_failure("word mismatch", want, got);
        end
      end
    end
    pending <= awaited_bytes.size();
  end

endmodule

### sim/lcd_pixel_command_serializer_tb.sv
`timescale 1ns / 1ps

module lcd_pixel_command_serializer_tb;
  import lpcs_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_PANEL_WIDTH;
  logic [9:0]  cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser = ACT_PIXEL;
  logic [63:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  int          failures;
  int          pending;
  int          in_idle_pct = 10;
  int          out_idle_pct = 50;

  lcd_pixel_command_serializer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  lcd_byte_stream_checker stream_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .failures   (failures),
    .pending    (pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= out_idle_pct);
  end

  initial begin
    #2_000_000;
    $display("lcd_pixel_command_serializer_tb: done, errors");
    $finish;
  end

  function automatic logic [63:0] pack_request(logic [9:0] sx, logic [9:0] sy,
                                               logic [9:0] ex, logic [9:0] ey,
                                               logic [15:0] colour, logic [2:0] mode);
    return {5'd0, mode, colour, ey, ex, sy, sx};
  endfunction

  task automatic send_request(logic [1:0] act, logic [63:0] word);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // drop valid, drain the stream, then allow dropped words to clear the pipeline
  task automatic drain;
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_panel(logic [9:0] cols, logic [9:0] rows);
    cfg_valid <= 1'b1;
    cfg_index <= REG_PANEL_WIDTH;
    cfg_data  <= cols;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_PANEL_HEIGHT;
    cfg_data  <= rows;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int          cols, rows, done_items, m;
    logic [1:0]  act;
    logic [9:0]  sx, sy;
    logic [2:0]  mode;
    logic [63:0] word;
    bit          ignored;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_request(ACT_PIXEL,  pack_request(10'd0, 10'd0, 10'd0, 10'd0, 16'h0000, 3'd0));
    send_request(ACT_PIXEL,  pack_request(10'd319, 10'd479, 10'd0, 10'd0, 16'hFFFF, 3'd0));
    send_request(ACT_PIXEL,  pack_request(10'd320, 10'd0, 10'd0, 10'd0, 16'h1234, 3'd0));
    send_request(ACT_PIXEL,  pack_request(10'd0, 10'd480, 10'd0, 10'd0, 16'h1234, 3'd0));
    send_request(ACT_PIXEL,  pack_request(10'd1023, 10'd1023, 10'd0, 10'd0, 16'hFFFF, 3'd7));
    send_request(ACT_PIXEL,  pack_request(10'd5, 10'd7, 10'h3FF, 10'h3FF, 16'hA5C3, 3'd7));
    send_request(ACT_WINDOW, pack_request(10'd0, 10'd0, 10'd1023, 10'd1023, 16'hFFFF, 3'd7));
    send_request(ACT_WINDOW, pack_request(10'd1023, 10'd1023, 10'd0, 10'd0, 16'h0000, 3'd0));
    send_request(ACT_WINDOW, pack_request(10'd256, 10'd511, 10'd767, 10'd300, 16'h0F0F, 3'd5));
    send_request(ACT_COLOR,  pack_request(10'd0, 10'd0, 10'd0, 10'd0, 16'hF800, 3'd0));
    send_request(ACT_COLOR,  pack_request(10'd0, 10'd0, 10'd0, 10'd0, 16'h07E0, 3'd0));
    send_request(ACT_COLOR,  pack_request(10'd0, 10'd0, 10'd0, 10'd0, 16'h001F, 3'd0));
    send_request(ACT_COLOR,  pack_request(10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 16'hFFFF, 3'd7));
    send_request(ACT_COLOR,  pack_request(10'd0, 10'd0, 10'd0, 10'd0, 16'h0000, 3'd0));
    for (m = 0; m < 8; m++)
      send_request(ACT_ORIENT, pack_request(10'd0, 10'd0, 10'd0, 10'd0, 16'h0000, 3'(m)));
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       begin cols = 1023; rows = 1023; end
        1:       begin cols = 1;    rows = 1;    end
        2:       begin cols = 0;    rows = 1023; end
        3:       begin cols = 1023; rows = 0;    end
        4:       begin cols = $urandom_range(1023, 1); rows = $urandom_range(1023, 1); end
        default: begin cols = 320;  rows = 480;  end
      endcase
      in_idle_pct  = (ph < 2) ? 10 : (ph < 4) ? 50 : 0;
      out_idle_pct = (ph < 2) ? 50 : (ph < 4) ? 10 : 0;
      write_panel(10'(cols), 10'(rows));

      done_items = 0;
      while (done_items < 70) begin
        act  = 2'($urandom_range(3));
        word = {5'd0, 59'({$urandom, $urandom})};
        sx   = word[9:0];
        sy   = word[19:10];
        if (act == ACT_PIXEL && $urandom_range(3) != 0) begin
          sx = 10'($urandom_range(cols));
          sy = 10'($urandom_range(rows));
          word[19:0] = {sy, sx};
        end
        if (act == ACT_ORIENT && $urandom_range(4) != 0)
          word[58:56] = 3'($urandom_range(3));
        mode = word[58:56];
        ignored = (act == ACT_PIXEL && (sx >= cols || sy >= rows)) ||
                  (act == ACT_ORIENT && mode > 3'd3);
        send_request(act, word);
        if (!ignored) done_items++;
      end
      drain();
    end

    if (failures == 0 && pending == 0)
      $display("lcd_pixel_command_serializer_tb: done, clean");
    else
      $display("lcd_pixel_command_serializer_tb: done, errors");
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/lpcs_pkg.sv
hdl/lpcs_front.sv
hdl/lpcs_queue.sv
hdl/lpcs_back.sv
hdl/lcd_pixel_command_serializer.sv
hdl/lpcs_checker.sv
sim/lcd_byte_stream_checker.sv
sim/lcd_pixel_command_serializer_tb.sv
